// ----- rtl/bmp_pkg.sv -----
`timescale 1ns / 1ps
package bmp_pkg;
  localparam int unsigned TableSize = 8192;
  localparam int unsigned IdxW = 13;
  localparam int unsigned ValW = 30;
  localparam logic [29:0] ModP = 30'd1000000007;
  localparam logic [29:0] ModExp = 30'd1000000005;
  localparam int unsigned QDepth = 4;

  typedef enum logic [2:0] {
    PH_FACT, PH_POWER, PH_INV, PH_READY
  } phase_t;

  // job passed from front to back
  typedef struct packed {
    logic        zero;
    logic [15:0] top;
    logic [15:0] bot;
    logic [15:0] diff;
  } job_t;
endpackage

// ----- rtl/bmp_mulmod.sv -----
`timescale 1ns / 1ps
// pipelined a*b mod p
// barrett reduction: estimate the quotient from the top product bits,
// subtract quotient*p on the low 32 bits, then conditional subtracts of 2p and of p
module bmp_mulmod (
  input  logic        clk,
  input  logic [29:0] a,
  input  logic [29:0] b,
  output logic [29:0] y
);
  // floor(2^60 / p), 31 bits
  localparam logic [30:0] Mu = 31'((64'd1 << 60) / 64'(bmp_pkg::ModP));
  logic [59:0] prod_r;
  logic [61:0] qm_r;
  logic [31:0] lo_r;
  logic [31:0] r_r;
  logic [29:0] y_r;
  logic [30:0] q;
  logic [60:0] qp;
  logic [31:0] u;

  // quotient estimate is at most two below the true quotient
  always_comb begin
    q  = qm_r[61:31];
    qp = 61'(q) * 61'(bmp_pkg::ModP);
  end

  // remainder is below 3p, bring it into range
  always_comb begin
    u = r_r;
    if (u >= 32'(bmp_pkg::ModP) * 32'd2) u = u - 32'(bmp_pkg::ModP) * 32'd2;
    if (u >= 32'(bmp_pkg::ModP)) u = u - 32'(bmp_pkg::ModP);
  end

  always_ff @(posedge clk) begin
    prod_r <= 60'(a) * 60'(b);
    qm_r   <= 62'(prod_r[59:29]) * 62'(Mu);
    lo_r   <= prod_r[31:0];
    r_r    <= lo_r - qp[31:0];
    y_r    <= u[29:0];
  end
  assign y = y_r;
endmodule

// ----- rtl/bmp_front.sv -----
`timescale 1ns / 1ps
// accepts queries, classifies them and pushes jobs into a short queue
module bmp_front #(
  parameter int unsigned TABLE_SIZE = bmp_pkg::TableSize
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               ready,
  input  logic [12:0]        in_top,
  input  logic [12:0]        in_bottom,
  input  logic               pop,
  output logic               busy,
  output logic               q_valid,
  output bmp_pkg::job_t      q_job
);
  localparam int unsigned QW = $clog2(bmp_pkg::QDepth);
  bmp_pkg::job_t q_r [bmp_pkg::QDepth];
  logic [QW-1:0] wp_r, rp_r;
  logic [QW:0]   cnt_r;
  logic          push;
  bmp_pkg::job_t job;

  // classify the item
  always_comb begin
    job.top  = 16'(in_top);
    job.bot  = 16'(in_bottom);
    job.diff = 16'(in_top) - 16'(in_bottom);
    job.zero = (in_bottom > in_top) || (32'(in_top) >= TABLE_SIZE);
    if (job.zero) begin
      job.top = '0; job.bot = '0; job.diff = '0;
    end
  end

  assign busy    = !ready || (cnt_r >= (QW+1)'(bmp_pkg::QDepth - 1));
  assign push    = start && !busy;
  assign q_valid = cnt_r != '0;
  assign q_job   = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= job;
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop && q_valid) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QW+1)'(push) - (QW+1)'(pop && q_valid);
    end
  end

  // queue never overflows
  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QW+1)'(bmp_pkg::QDepth)) else $error("queue overflow");
endmodule

// ----- rtl/bmp_back.sv -----
`timescale 1ns / 1ps
// builds the tables, then serves jobs: reads, two modular multiplies
module bmp_back #(
  parameter int unsigned TABLE_SIZE = bmp_pkg::TableSize
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  bmp_pkg::job_t q_job,
  output logic          pop,
  output logic          ready,
  output logic          out_valid,
  output logic [29:0]   out_value
);
  localparam int unsigned AW = (TABLE_SIZE > 2) ? $clog2(TABLE_SIZE) : 1;
  localparam int unsigned ML = 4;

  logic [29:0] fact_m [TABLE_SIZE];
  logic [29:0] inv_m  [TABLE_SIZE];
  logic [29:0] inv2_m [TABLE_SIZE];

  bmp_pkg::phase_t ph_r, ph_nxt;
  logic [AW:0]  idx_r, idx_nxt;
  logic [29:0]  acc_r, acc_nxt, sq_r, sq_nxt, prev_r, prev_nxt;
  logic [4:0]   bit_r, bit_nxt;
  logic [2:0]   step_r, step_nxt;
  logic         wf, wi;
  logic [AW-1:0] wa;
  logic [29:0]  wd;

  logic [29:0] ma, mb, my, na, nb, ny;
  logic [29:0] rf_r, ri_r, rd_r;
  logic        s1_r, z1_r;
  logic [ML-1:0] v2_r, z2_r;
  logic [29:0] ri2_r [ML];
  logic [ML-1:0] v3_r, z3_r;

  bmp_mulmod u_m1 (.clk(clk), .a(ma), .b(mb), .y(my));
  bmp_mulmod u_m2 (.clk(clk), .a(na), .b(nb), .y(ny));

  assign ready = (ph_r == bmp_pkg::PH_READY);
  assign pop   = ready && q_valid;

  // build sequencer: one multiply in flight (two in the power phase), waits its latency
  always_comb begin
    ph_nxt = ph_r; idx_nxt = idx_r; acc_nxt = acc_r; sq_nxt = sq_r;
    prev_nxt = prev_r; bit_nxt = bit_r; step_nxt = step_r;
    wf = 1'b0; wi = 1'b0; wa = idx_r[AW-1:0]; wd = my;
    ma = rf_r; mb = ri_r;
    unique case (ph_r)
      bmp_pkg::PH_FACT: begin
        ma = prev_r; mb = 30'(idx_r);
        if (idx_r == '0) begin
          wf = 1'b1; wd = 30'd1; prev_nxt = 30'd1; idx_nxt = (AW+1)'(1);
        end else begin
          step_nxt = step_r + 1'b1;
          if (step_r == 3'(ML)) begin
            step_nxt = '0; wf = 1'b1; prev_nxt = my;
            if (32'(idx_r) == TABLE_SIZE - 1) begin
              ph_nxt = bmp_pkg::PH_POWER; sq_nxt = my; acc_nxt = 30'd1;
              bit_nxt = '0;
            end else idx_nxt = idx_r + 1'b1;
          end
        end
      end
      bmp_pkg::PH_POWER: begin
        // acc*sq issued on step 0, sq*sq on step 1, back on steps 4 and 5
        ma = (step_r == 3'd1) ? sq_r : acc_r; mb = sq_r;
        step_nxt = step_r + 1'b1;
        if (step_r == 3'(ML)) begin
          if (bmp_pkg::ModExp[bit_r]) acc_nxt = my;
        end else if (step_r == 3'(ML + 1)) begin
          sq_nxt = my; step_nxt = '0;
          if (bit_r == 5'd29) begin
            ph_nxt = bmp_pkg::PH_INV; prev_nxt = acc_r;
          end else bit_nxt = bit_r + 1'b1;
        end
      end
      bmp_pkg::PH_INV: begin
        ma = prev_r; mb = 30'(idx_r);
        if (step_r == 3'd0 && 32'(idx_r) == TABLE_SIZE - 1 && prev_r == acc_r
            && bit_r == 5'd29) begin
          wi = 1'b1; wd = acc_r; bit_nxt = '0; step_nxt = '0;
        end else begin
          step_nxt = step_r + 1'b1;
          if (step_r == 3'(ML)) begin
            step_nxt = '0; wi = 1'b1; wa = idx_r[AW-1:0] - 1'b1; prev_nxt = my;
            idx_nxt = idx_r - 1'b1;
            if (idx_r == (AW+1)'(1)) ph_nxt = bmp_pkg::PH_READY;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= bmp_pkg::PH_FACT; idx_r <= '0; acc_r <= 30'd1;
      step_r <= '0; bit_r <= '0;
    end else begin
      ph_r <= ph_nxt; idx_r <= idx_nxt; acc_r <= acc_nxt;
      step_r <= step_nxt; bit_r <= bit_nxt;
    end
    sq_r <= sq_nxt; prev_r <= prev_nxt;
  end

  // table memories, one write port, registered reads
  always_ff @(posedge clk) begin
    if (wf) fact_m[wa] <= wd;
    if (wi) begin
      inv_m[wa] <= wd; inv2_m[wa] <= wd;
    end
    rf_r <= fact_m[q_job.top[AW-1:0]];
    ri_r <= inv_m[q_job.bot[AW-1:0]];
    rd_r <= inv2_m[q_job.diff[AW-1:0]];
  end

  // query pipeline: read, mul1, delay, mul2
  assign na = my; assign nb = ri2_r[ML-1];
  always_ff @(posedge clk) begin
    ri2_r[0] <= rd_r;
    for (int k = 1; k < ML; k++) ri2_r[k] <= ri2_r[k-1];
    if (!rst_n) begin
      s1_r <= 1'b0; z1_r <= 1'b0; v2_r <= '0; z2_r <= '0; v3_r <= '0; z3_r <= '0;
    end else begin
      s1_r <= pop; z1_r <= q_job.zero;
      v2_r <= {v2_r[ML-2:0], s1_r}; z2_r <= {z2_r[ML-2:0], z1_r};
      v3_r <= {v3_r[ML-2:0], v2_r[ML-1]}; z3_r <= {z3_r[ML-2:0], z2_r[ML-1]};
    end
  end

  assign out_valid = v3_r[ML-1];
  assign out_value = z3_r[ML-1] ? '0 : ny;

  // no query result while still building
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ready) else $error("result during build");
  assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid) else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (!rst_n)
    (wf && wi) == 1'b0) else $error("two table writes");
endmodule

// ----- rtl/binomial_mod_prime.sv -----
`timescale 1ns / 1ps
// channel | ports                         | handshake
// query   | in_top, in_bottom             | start, busy
// result  | out_value                     | out_valid, one cycle
// one query accepted per cycle while busy is low; each result is strobed after its query leaves the queue
// after reset, busy stays high while the tables are built: factorial fill,
// then the power that inverts the last factorial, then the inverse fill
// rst_n is synchronous active low; results cannot be stalled
module binomial_mod_prime #(
  parameter int unsigned TABLE_SIZE = bmp_pkg::TableSize
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [12:0] in_top,
  input  logic [12:0] in_bottom,
  output logic        out_valid,
  output logic [29:0] out_value
);
  logic          ready, pop, q_valid;
  bmp_pkg::job_t q_job;

  bmp_front #(.TABLE_SIZE(TABLE_SIZE)) u_front (
    .clk, .rst_n, .start, .ready, .in_top, .in_bottom, .pop,
    .busy, .q_valid, .q_job);

  bmp_back #(.TABLE_SIZE(TABLE_SIZE)) u_back (
    .clk, .rst_n, .q_valid, .q_job, .pop, .ready, .out_valid, .out_value);
endmodule
